// ----- design/fbp_pkg.sv -----
// Shared types, constants and pixel arithmetic for the frame store plot/fade unit.
// No dependencies; imported by the ALU and the top level.
package fbp_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(PIXELS);
  localparam int IN_ADDR_W    = 17;
  localparam int WORD_W       = 32;

  localparam logic [WORD_W-1:0] HALF_MASK = 32'h7F7F7F7F;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_PLOT      = 2'd0;
  localparam logic [1:0] OP_FADE_BLUR = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FADE_SHIFT       = 2'd0;
  localparam logic [1:0] CFG_BRIGHTNESS_SHIFT = 2'd1;
  localparam logic [1:0] CFG_DEPTH_SHIFT      = 2'd2;
  localparam logic [1:0] CFG_DEPTH_ENABLE     = 2'd3;

  typedef enum logic [1:0] {
    ALU_PLOT,
    ALU_FADE_LANE,
    ALU_FADE_DEPTH,
    ALU_AVG
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t  mode;
    logic [2:0] fade_shift;
    logic [2:0] brightness_shift;
    logic [2:0] depth_shift;
    logic       depth_enable;
  } alu_ctrl_t;

  typedef struct packed {
    logic [7:0] intensity;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } plot_tgt_t;

  // Ease v toward tgt: ((v+1)*(2^s-1)+tgt) >> s, result up to 255
  function automatic logic [8:0] ease(input logic [7:0] v, input logic [7:0] tgt,
                                      input logic [2:0] s);
    logic [15:0] p;
    logic [15:0] sum;
    p   = 16'(v) + 16'd1;
    sum = (p << s) - p + 16'(tgt);
    return 9'(sum >> s);
  endfunction

  // Bytewise fade; depth_only restricts it to the top byte
  function automatic logic [WORD_W-1:0] fade_word(input logic [WORD_W-1:0] w,
                                                   input logic [2:0] f,
                                                   input logic depth_only);
    logic [7:0]        bb;
    logic [7:0]        mb;
    logic [WORD_W-1:0] bias;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] sum;
    bb = 8'((16'd1 << f) - 16'd1);
    mb = 8'((16'd1 << (4'd8 - {1'b0, f})) - 16'd1);
    if (depth_only) begin
      bias = {bb, 24'd0};
      mask = {mb, 24'd0};
    end else begin
      bias = {4{bb}};
      mask = {4{mb}};
    end
    sum = w + bias;
    return w - ((sum >> f) & mask);
  endfunction

  // Bytewise floor average of two words
  function automatic logic [WORD_W-1:0] avg_bytes(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
    return (((a ^ b) >> 1) & HALF_MASK) + (a & b);
  endfunction

endpackage

// ----- design/fbp_ram.sv -----
// Generic frame store RAM: one write port, two registered read ports.
// No dependencies.
module fbp_ram #(
  parameter int DEPTH = 76800,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- design/fbp_alu.sv -----
// Shared pixel unit: plot update, lane and depth fades, bytewise average.
// Depends on fbp_pkg.
module fbp_alu (
  input  fbp_pkg::alu_ctrl_t             ctrl,
  input  fbp_pkg::plot_tgt_t             tgt,
  input  logic [fbp_pkg::WORD_W-1:0]     word_a,
  input  logic [fbp_pkg::WORD_W-1:0]     word_b,
  output logic [fbp_pkg::WORD_W-1:0]     result,
  output logic                           accept
);
  import fbp_pkg::*;

  logic [8:0] t_depth;
  logic [8:0] t_blue;
  logic [8:0] t_green;
  logic [8:0] t_red;
  logic [7:0] new_depth;
  logic [7:0] new_blue;
  logic [7:0] new_green;
  logic [7:0] new_red;
  logic       reject;

  // Plot path: depth easing and test, colour easing with max-blend
  always_comb begin
    t_depth   = ease(word_a[31:24], tgt.intensity, ctrl.depth_shift);
    t_blue    = ease(word_a[7:0],   tgt.blue,      ctrl.brightness_shift);
    t_green   = ease(word_a[15:8],  tgt.green,     ctrl.brightness_shift);
    t_red     = ease(word_a[23:16], tgt.red,       ctrl.brightness_shift);
    reject    = ctrl.depth_enable && ({2'b00, word_a[31:24]} >= ({1'b0, t_depth} + 10'd2));
    new_depth = ctrl.depth_enable ? t_depth[7:0] : word_a[31:24];
    new_blue  = ({1'b0, word_a[7:0]}   < t_blue)  ? t_blue[7:0]  : word_a[7:0];
    new_green = ({1'b0, word_a[15:8]}  < t_green) ? t_green[7:0] : word_a[15:8];
    new_red   = ({1'b0, word_a[23:16]} < t_red)   ? t_red[7:0]   : word_a[23:16];
  end

  // Mode select
  always_comb begin
    accept = 1'b1;
    case (ctrl.mode)
      ALU_PLOT: begin
        result = {new_depth, new_red, new_green, new_blue};
        accept = !reject;
      end
      ALU_FADE_LANE:  result = fade_word(word_a, ctrl.fade_shift, 1'b0);
      ALU_FADE_DEPTH: result = fade_word(word_a, ctrl.fade_shift, 1'b1);
      default:        result = avg_bytes(word_a, word_b);
    endcase
  end

endmodule

// ----- design/framebuffer_fade_blur_plot_unit.sv -----
// Top level of the frame store plot/fade unit: sequencer, configuration, output stage.
// Depends on fbp_pkg, fbp_ram and fbp_alu.
//
// After reset the unit clears its 76800-word frame store, one word a cycle, so in_ready
// stays low until the sweep ends; configuration writes are taken meanwhile. A plot or
// read transaction is one read-modify-write of the store: accept, read, update/write,
// stage the result, and the unit is ready again as soon as the result is staged, even
// while it still waits at the output. A fade_blur transaction streams the store through
// the shared pixel unit once per pass, one word a cycle through the store's two read
// ports and one write port: a lane fade, a depth fade when depth is enabled, then
// forward, backward, down and up averages. Each pass ends in a drain state; together
// the passes update 6*PIXELS - 2*FRAME_WIDTH - 2 words (PIXELS fewer without depth).
module framebuffer_fade_blur_plot_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic [fbp_pkg::IN_ADDR_W-1:0]   in_pixel_address,
  input  logic [7:0]                      in_intensity,
  input  logic [8:0]                      in_red_weight,
  input  logic [8:0]                      in_green_weight,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fbp_pkg::WORD_W-1:0]      out_pixel_word,
  output logic                            out_plotted,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [2:0]                      cfg_wdata
);
  import fbp_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(FRAME_WIDTH);
  localparam logic [ADDR_W-1:0] FWD_LAST  = ADDR_W'(PIXELS - 2);
  localparam logic [ADDR_W-1:0] DOWN_LAST = ADDR_W'(PIXELS - FRAME_WIDTH - 1);
  localparam logic [ADDR_W-1:0] ONE_ADDR  = ADDR_W'(1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WB,
    ST_PASS,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PS_FADE_LANE,
    PS_FADE_DEPTH,
    PS_FWD,
    PS_BWD,
    PS_DOWN,
    PS_UP
  } pass_t;

  state_t            state_r;
  pass_t             pass_r;
  logic [ADDR_W-1:0] j_r;
  logic              pv_r;
  logic [ADDR_W-1:0] pa_r;

  logic              plot_r;
  logic              in_range_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        c_r;
  logic [8:0]        rc_r;
  logic [8:0]        gc_r;
  plot_tgt_t         tgt_r;

  logic [WORD_W-1:0] res_word_r;
  logic              res_plot_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_plot_r;

  logic [2:0]        fade_shift_r;
  logic [2:0]        brightness_shift_r;
  logic [2:0]        depth_shift_r;
  logic              depth_enable_r;

  logic [16:0]       red_prod;
  logic [16:0]       green_prod;
  logic [9:0]        rg_sum;
  logic [9:0]        c_twice;
  logic [9:0]        blue_diff;
  logic [7:0]        blue_tgt;
  logic [7:0]        green_tgt;
  logic [7:0]        red_tgt;

  logic [ADDR_W-1:0] pass_x;
  logic [ADDR_W-1:0] pass_y;
  logic [ADDR_W-1:0] pass_last;
  logic              pass_desc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr_a;
  logic [ADDR_W-1:0] ram_raddr_b;
  logic [WORD_W-1:0] ram_rdata_a;
  logic [WORD_W-1:0] ram_rdata_b;

  alu_ctrl_t         alu_ctrl;
  logic [WORD_W-1:0] alu_result;
  logic              alu_accept;
  logic              accept_in;
  logic              out_free;

  assign in_ready       = (state_r == ST_IDLE);
  assign accept_in      = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_pixel_word = out_word_r;
  assign out_plotted    = out_plot_r;

  // Colour weights: product taken at acceptance
  assign red_prod   = 17'(in_intensity) * 17'(in_red_weight);
  assign green_prod = 17'(in_intensity) * 17'(in_green_weight);

  // Colour targets from the registered shares
  always_comb begin
    rg_sum    = {1'b0, rc_r} + {1'b0, gc_r};
    c_twice   = {1'b0, c_r, 1'b0};
    blue_diff = c_twice - rg_sum;
    blue_tgt  = (rg_sum > c_twice) ? 8'd0 : blue_diff[8:1];
    green_tgt = (gc_r > 9'd255) ? 8'd255 : gc_r[7:0];
    red_tgt   = (rc_r > 9'd255) ? 8'd255 : rc_r[7:0];
  end

  // Pass geometry: read addresses, end index and direction
  always_comb begin
    pass_x    = j_r;
    pass_y    = j_r;
    pass_last = LAST_ADDR;
    pass_desc = 1'b0;
    case (pass_r)
      PS_FWD: begin
        pass_y    = j_r + ONE_ADDR;
        pass_last = FWD_LAST;
      end
      PS_BWD: begin
        pass_x    = j_r - ONE_ADDR;
        pass_last = ONE_ADDR;
        pass_desc = 1'b1;
      end
      PS_DOWN: begin
        pass_y    = j_r + ROW_STEP;
        pass_last = DOWN_LAST;
      end
      PS_UP: begin
        pass_x    = j_r - ROW_STEP;
        pass_last = ROW_STEP;
        pass_desc = 1'b1;
      end
      default: begin
        pass_x = j_r;
      end
    endcase
  end

  // Shared unit control
  always_comb begin
    alu_ctrl.fade_shift       = fade_shift_r;
    alu_ctrl.brightness_shift = brightness_shift_r;
    alu_ctrl.depth_shift      = depth_shift_r;
    alu_ctrl.depth_enable     = depth_enable_r;
    if (state_r == ST_WB) begin
      alu_ctrl.mode = ALU_PLOT;
    end else begin
      case (pass_r)
        PS_FADE_LANE:  alu_ctrl.mode = ALU_FADE_LANE;
        PS_FADE_DEPTH: alu_ctrl.mode = ALU_FADE_DEPTH;
        default:       alu_ctrl.mode = ALU_AVG;
      endcase
    end
  end

  // Store ports
  always_comb begin
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    if (state_r == ST_PASS) begin
      ram_raddr_a = pass_x;
      ram_raddr_b = pass_y;
    end else if (state_r == ST_RD) begin
      ram_raddr_a = in_range_r ? addr_r : '0;
    end
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = j_r;
      ram_wdata = '0;
    end else if (pv_r) begin
      ram_we    = 1'b1;
      ram_waddr = pa_r;
      ram_wdata = alu_result;
    end else begin
      ram_we    = (state_r == ST_WB) && plot_r && in_range_r && alu_accept;
      ram_waddr = addr_r;
      ram_wdata = alu_result;
    end
  end

  fbp_ram #(
    .DEPTH (PIXELS),
    .WIDTH (WORD_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  fbp_alu u_alu (
    .ctrl   (alu_ctrl),
    .tgt    (tgt_r),
    .word_a (ram_rdata_a),
    .word_b (ram_rdata_b),
    .result (alu_result),
    .accept (alu_accept)
  );

  // Sequencer, configuration and output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_CLEAR;
      pass_r             <= PS_FADE_LANE;
      j_r                <= '0;
      pv_r               <= 1'b0;
      out_valid_r        <= 1'b0;
      fade_shift_r       <= 3'd4;
      brightness_shift_r <= 3'd5;
      depth_shift_r      <= 3'd2;
      depth_enable_r     <= 1'b1;
    end else begin
      pv_r <= (state_r == ST_PASS);
      pa_r <= j_r;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FADE_SHIFT:       fade_shift_r       <= cfg_wdata;
          CFG_BRIGHTNESS_SHIFT: brightness_shift_r <= cfg_wdata;
          CFG_DEPTH_SHIFT:      depth_shift_r      <= cfg_wdata;
          CFG_DEPTH_ENABLE:     depth_enable_r     <= cfg_wdata[0];
        endcase
      end

      // the done state restages the output itself
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          if (j_r == LAST_ADDR) begin
            j_r     <= '0;
            state_r <= ST_IDLE;
          end else begin
            j_r <= j_r + ONE_ADDR;
          end
        end
        ST_IDLE: begin
          if (accept_in) begin
            plot_r     <= (in_opcode == OP_PLOT);
            in_range_r <= (32'(in_pixel_address) < 32'(PIXELS));
            addr_r     <= ADDR_W'(in_pixel_address);
            c_r        <= in_intensity;
            rc_r       <= red_prod[16:8];
            gc_r       <= green_prod[16:8];
            res_word_r <= '0;
            res_plot_r <= 1'b0;
            case (in_opcode)
              OP_PLOT, OP_READ: state_r <= ST_RD;
              OP_FADE_BLUR: begin
                pass_r  <= PS_FADE_LANE;
                j_r     <= '0;
                state_r <= ST_PASS;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_RD: begin
          tgt_r.intensity <= c_r;
          tgt_r.blue      <= blue_tgt;
          tgt_r.green     <= green_tgt;
          tgt_r.red       <= red_tgt;
          state_r         <= ST_WB;
        end
        ST_WB: begin
          if (plot_r) begin
            res_word_r <= (in_range_r && alu_accept) ? alu_result : '0;
            res_plot_r <= in_range_r && alu_accept;
          end else begin
            res_word_r <= in_range_r ? ram_rdata_a : '0;
            res_plot_r <= 1'b0;
          end
          state_r <= ST_DONE;
        end
        ST_PASS: begin
          if (j_r == pass_last) begin
            state_r <= ST_DRAIN;
          end else if (pass_desc) begin
            j_r <= j_r - ONE_ADDR;
          end else begin
            j_r <= j_r + ONE_ADDR;
          end
        end
        ST_DRAIN: begin
          // last write of the pass lands this cycle; pick the next pass
          state_r <= (pass_r == PS_UP) ? ST_DONE : ST_PASS;
          case (pass_r)
            PS_FADE_LANE: begin
              pass_r <= depth_enable_r ? PS_FADE_DEPTH : PS_FWD;
              j_r    <= '0;
            end
            PS_FADE_DEPTH: begin
              pass_r <= PS_FWD;
              j_r    <= '0;
            end
            PS_FWD: begin
              pass_r <= PS_BWD;
              j_r    <= LAST_ADDR;
            end
            PS_BWD: begin
              pass_r <= PS_DOWN;
              j_r    <= '0;
            end
            PS_DOWN: begin
              pass_r <= PS_UP;
              j_r    <= LAST_ADDR;
            end
            default: begin
              // up pass ends the transaction
              j_r <= '0;
            end
          endcase
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_word_r  <= res_word_r;
            out_plot_r  <= res_plot_r;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- design/fbp_checker.sv -----
// Port-level checks of the frame store plot/fade unit, bound to its top level.
// No package dependency; attaches to framebuffer_fade_blur_plot_unit.
module fbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_word,
  input logic        out_plotted
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_word) && $stable(out_plotted))
    else $error("result changed while stalled");

  // One transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // Reset starts the clearing sweep with an empty output stage
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("not busy after reset");

  // Staging a result frees the input side
  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result staged but input not ready");

endmodule

bind framebuffer_fade_blur_plot_unit fbp_checker u_fbp_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for framebuffer_fade_blur_plot_unit: a shadow frame store predicts
// every plot, read and fade/blur result. Depends on fbp_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
  import fbp_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT = 2_000_000;
  localparam int         PER_PHASE  = 205;

  typedef struct {
    logic [1:0]  opcode;
    logic [16:0] address;
    logic [7:0]  intensity;
    logic [8:0]  red_w;
    logic [8:0]  green_w;
    bit          drain_first;
  } pixel_cmd_t;

  typedef struct {
    logic [31:0] word;
    logic        plotted;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_PLOT;
  logic [16:0] in_pixel_address = '0;
  logic [7:0]  in_intensity = '0;
  logic [8:0]  in_red_weight = '0;
  logic [8:0]  in_green_weight = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel_word;
  logic        out_plotted;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FADE_SHIFT;
  logic [2:0]  cfg_wdata = '0;

  // Shadow copy of the frame store and registers
  logic [31:0] shadow_frame [PIXELS];
  logic [2:0]  fade_sh = 3'd4;
  logic [2:0]  bright_sh = 3'd5;
  logic [2:0]  depth_sh = 3'd2;
  logic        depth_on = 1'b1;

  pixel_cmd_t    cmd_q[$];
  pixel_result_t pending_results[$];
  int            hot_addr[24];

  bit in_taken = 1'b0;
  bit bench_idle = 1'b0;
  int gap_left = 0;
  int burst_left = 1;
  int idle_cycles = 0;
  int n_errors = 0;
  int n_cmds = 0;
  int n_drawn = 0;
  int n_reads = 0;
  int n_fades = 0;
  int n_settings = 0;
  logic [7:0] stall_pat = 8'hFF;
  int         stall_left = 0;

  framebuffer_fade_blur_plot_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_pixel_address (in_pixel_address),
    .in_intensity     (in_intensity),
    .in_red_weight    (in_red_weight),
    .in_green_weight  (in_green_weight),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_word   (out_pixel_word),
    .out_plotted      (out_plotted),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ((v+1)*(2^s-1)+target) >> s
  function automatic int unsigned ease_byte(int unsigned v, int unsigned target,
                                            int unsigned s);
    int unsigned p;
    p = v + 1;
    return ((p << s) - p + target) >> s;
  endfunction

  function automatic logic [31:0] fade_word(logic [31:0] w, logic [31:0] lanes,
                                            int unsigned f);
    logic [31:0] bias;
    logic [31:0] mask;
    bias = ((32'd1 << f) - 32'd1) * lanes;
    mask = ((32'd1 << (8 - f)) - 32'd1) * lanes;
    return w - (((w + bias) >> f) & mask);
  endfunction

  // Per-byte floor mean of two words
  function automatic logic [31:0] mean_bytes(logic [31:0] a, logic [31:0] b);
    logic [31:0] m;
    logic [8:0]  s;
    for (int k = 0; k < 4; k++) begin
      s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      m[8*k +: 8] = s[8:1];
    end
    return m;
  endfunction

  // Depth-tested translucent plot into the shadow store
  task automatic plot_pixel(int adr, int unsigned c, int unsigned r, int unsigned g,
                            output logic [31:0] word, output logic drawn);
    int unsigned lane[4];
    int unsigned tgt[3];
    int unsigned t;
    int unsigned rc;
    int unsigned gc;
    logic [31:0] w;
    word  = '0;
    drawn = 1'b0;
    w = shadow_frame[adr];
    for (int k = 0; k < 4; k++) lane[k] = (w >> (8 * k)) & 32'hFF;
    if (depth_on) begin
      t = ease_byte(lane[3], c, depth_sh);
      if (lane[3] >= t + 2) return;
      lane[3] = t & 32'hFF;
    end
    rc = (c * r) >> 8;
    gc = (c * g) >> 8;
    tgt[0] = (rc + gc > 2 * c) ? 0 : (2 * c - rc - gc) >> 1;
    tgt[1] = (gc > 255) ? 255 : gc;
    tgt[2] = (rc > 255) ? 255 : rc;
    for (int k = 0; k < 3; k++) begin
      t = ease_byte(lane[k], tgt[k], bright_sh);
      if (lane[k] < t) lane[k] = t & 32'hFF;
    end
    w = (lane[3] << 24) | (lane[2] << 16) | (lane[1] << 8) | lane[0];
    shadow_frame[adr] = w;
    word  = w;
    drawn = 1'b1;
  endtask

  // Whole-frame fade followed by the four blur passes
  task automatic fade_frame();
    for (int i = 0; i < PIXELS; i++)
      shadow_frame[i] = fade_word(shadow_frame[i], 32'h01010101, fade_sh);
    if (depth_on)
      for (int i = 0; i < PIXELS; i++)
        shadow_frame[i] = fade_word(shadow_frame[i], 32'h01000000, fade_sh);
    for (int i = 0; i + 1 < PIXELS; i++)
      shadow_frame[i] = mean_bytes(shadow_frame[i], shadow_frame[i+1]);
    for (int i = PIXELS - 1; i > 0; i--)
      shadow_frame[i] = mean_bytes(shadow_frame[i-1], shadow_frame[i]);
    for (int i = 0; i + FRAME_WIDTH < PIXELS; i++)
      shadow_frame[i] = mean_bytes(shadow_frame[i], shadow_frame[i+FRAME_WIDTH]);
    for (int i = PIXELS - 1; i >= FRAME_WIDTH; i--)
      shadow_frame[i] = mean_bytes(shadow_frame[i-FRAME_WIDTH], shadow_frame[i]);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // Accept, predict, check; also the watchdog and the idle flag
  always @(posedge clk) begin
    pixel_result_t res;
    pixel_result_t want;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h plotted %0b",
                                    out_pixel_word, out_plotted));
        end else begin
          want = pending_results.pop_front();
          if (out_pixel_word !== want.word)
            report_mismatch($sformatf("pixel_word %h, predicted %h",
                                      out_pixel_word, want.word));
          if (out_plotted !== want.plotted)
            report_mismatch($sformatf("plotted %0b, predicted %0b",
                                      out_plotted, want.plotted));
          if (want.plotted) n_drawn++;
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        res.word    = '0;
        res.plotted = 1'b0;
        case (in_opcode)
          OP_PLOT:
            if (in_pixel_address < PIXELS)
              plot_pixel(in_pixel_address, in_intensity, in_red_weight, in_green_weight,
                         res.word, res.plotted);
          OP_FADE_BLUR: begin
            fade_frame();
            n_fades++;
          end
          OP_READ: begin
            n_reads++;
            if (in_pixel_address < PIXELS) res.word = shadow_frame[in_pixel_address];
          end
          default: ;
        endcase
        pending_results.push_back(res);
      end
      in_taken <= in_valid && in_ready;
      bench_idle <= (cmd_q.size() == 0) && !in_valid && (pending_results.size() == 0)
                    && in_ready;
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("[framebuffer_fade_blur_plot_unit] ERROR");
        $finish;
      end
    end
  end

  // Sender: bursts and gaps, optional drain before a marked command
  always @(negedge clk) begin
    pixel_cmd_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0 &&
                   !(cmd_q[0].drain_first && pending_results.size() != 0)) begin
        nxt = cmd_q.pop_front();
        in_opcode        <= nxt.opcode;
        in_pixel_address <= nxt.address;
        in_intensity     <= nxt.intensity;
        in_red_weight    <= nxt.red_w;
        in_green_weight  <= nxt.green_w;
        in_valid         <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(10, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: rotating stall pattern, reloaded now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(50, 300);
      if ($urandom_range(0, 2) == 0) stall_pat = 8'hFF;
      else stall_pat = 8'($urandom) | (8'd1 << $urandom_range(0, 7));
    end
    stall_left--;
    stall_pat = {stall_pat[6:0], stall_pat[7]};
    out_ready <= stall_pat[0];
  end

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FADE_SHIFT:       fade_sh   = val;
      CFG_BRIGHTNESS_SHIFT: bright_sh = val;
      CFG_DEPTH_SHIFT:      depth_sh  = val;
      CFG_DEPTH_ENABLE:     depth_on  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain the unit if asked, then load a new register setting
  task automatic begin_phase(bit drain, logic [2:0] f, logic [2:0] b, logic [2:0] d,
                             logic e);
    if (drain) begin
      do @(negedge clk); while (!bench_idle);
    end
    write_reg(CFG_FADE_SHIFT, f);
    write_reg(CFG_BRIGHTNESS_SHIFT, b);
    write_reg(CFG_DEPTH_SHIFT, d);
    write_reg(CFG_DEPTH_ENABLE, {2'b00, e});
    n_settings++;
    // new commands are queued away from the sampling edge
    @(negedge clk);
  endtask

  task automatic push_cmd(logic [1:0] op, int adr, int c, int r, int g, bit drain = 1'b0);
    pixel_cmd_t pc;
    pc.opcode      = op;
    pc.address     = adr[16:0];
    pc.intensity   = c[7:0];
    pc.red_w       = r[8:0];
    pc.green_w     = g[8:0];
    pc.drain_first = drain;
    cmd_q.push_back(pc);
    n_cmds++;
  endtask

  // Mostly plots and reads on a small cluster, so pixels get revisited and depth-rejected
  task automatic push_random(int count);
    int sel;
    int adr;
    int c;
    int r;
    int g;
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) adr = hot_addr[$urandom_range(0, 23)];
      else if (sel < 85) adr = $urandom_range(0, PIXELS - 1);
      else adr = $urandom_range(0, 131071);
      sel = $urandom_range(0, 99);
      op = (sel < 60) ? OP_PLOT : (sel < 95) ? OP_READ : OP_UNUSED;
      sel = $urandom_range(0, 9);
      c = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
      sel = $urandom_range(0, 19);
      r = (sel < 2) ? 0 : (sel < 4) ? 256 : (sel < 7) ? $urandom_range(257, 511)
                                                       : $urandom_range(0, 256);
      sel = $urandom_range(0, 19);
      g = (sel < 2) ? 0 : (sel < 4) ? 256 : (sel < 7) ? $urandom_range(257, 511)
                                                       : $urandom_range(0, 256);
      push_cmd(op, adr, c, r, g, $urandom_range(0, 49) == 0);
    end
  endtask

  initial begin
    for (int i = 0; i < PIXELS; i++) shadow_frame[i] = '0;
    // 4x4 patch from row 10, column 10, plus frame corners and bit-16 neighbours
    for (int i = 0; i < 16; i++) hot_addr[i] = (10 + i / 4) * FRAME_WIDTH + 10 + i % 4;
    hot_addr[16] = 0;
    hot_addr[17] = FRAME_WIDTH - 1;
    hot_addr[18] = FRAME_WIDTH;
    hot_addr[19] = PIXELS - 1;
    hot_addr[20] = PIXELS - FRAME_WIDTH;
    hot_addr[21] = 65535;
    hot_addr[22] = 65536;
    hot_addr[23] = 65536 + FRAME_WIDTH;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, saturation, rejection, out-of-range, unused opcode, fade
    begin_phase(1'b0, 3'd1, 3'd5, 3'd2, 1'b1);
    push_cmd(OP_READ, 0, 0, 0, 0);
    push_cmd(OP_PLOT, 0, 255, 256, 0);
    push_cmd(OP_PLOT, 0, 255, 0, 256);
    push_cmd(OP_PLOT, PIXELS - 1, 255, 128, 128);
    push_cmd(OP_PLOT, 1, 0, 0, 0);
    push_cmd(OP_PLOT, 2, 200, 511, 511);
    push_cmd(OP_PLOT, 2, 0, 0, 0);
    push_cmd(OP_PLOT, PIXELS, 255, 256, 256);
    push_cmd(OP_PLOT, 131071, 255, 511, 511);
    push_cmd(OP_READ, PIXELS - 1, 0, 0, 0);
    push_cmd(OP_READ, PIXELS, 0, 0, 0);
    push_cmd(OP_READ, 131071, 255, 511, 511);
    push_cmd(OP_UNUSED, 131071, 255, 511, 511);
    push_cmd(OP_PLOT, 65536, 128, 300, 100);
    push_cmd(OP_PLOT, FRAME_WIDTH, 255, 256, 256);
    push_cmd(OP_READ, 0, 0, 0, 0);
    push_cmd(OP_FADE_BLUR, 0, 0, 0, 0, 1'b1);
    push_cmd(OP_READ, 0, 0, 0, 0);
    push_cmd(OP_READ, 1, 0, 0, 0);
    push_cmd(OP_READ, FRAME_WIDTH, 0, 0, 0);
    push_cmd(OP_READ, FRAME_WIDTH + 1, 0, 0, 0);
    push_cmd(OP_READ, PIXELS - 1, 0, 0, 0);
    push_cmd(OP_READ, PIXELS - FRAME_WIDTH - 1, 0, 0, 0);
    push_cmd(OP_READ, 65536, 0, 0, 0);
    push_cmd(OP_READ, 65536 - FRAME_WIDTH - 1, 0, 0, 0);

    // Random phases over a range of register settings, zero shifts included
    begin_phase(1'b1, 3'd4, 3'd0, 3'd0, 1'b1);
    push_random(PER_PHASE);
    begin_phase(1'b1, 3'd7, 3'd7, 3'd7, 1'b1);
    push_random(PER_PHASE);
    begin_phase(1'b1, 3'd3, 3'd3, 3'd5, 1'b0);
    push_random(PER_PHASE);
    begin_phase(1'b1, 3'd2, 3'd1, 3'd1, 1'b1);
    push_random(PER_PHASE);
    // Depth test off with the slowest fade, a whole-frame pass in the middle
    begin_phase(1'b1, 3'd7, 3'd4, 3'd3, 1'b0);
    push_random(100);
    push_cmd(OP_FADE_BLUR, $urandom_range(0, 131071), $urandom_range(0, 255),
             $urandom_range(0, 511), $urandom_range(0, 511), 1'b1);
    push_random(PER_PHASE - 100);
    begin_phase(1'b1, 3'($urandom), 3'($urandom), 3'($urandom), 1'($urandom));
    push_random(PER_PHASE);

    do @(negedge clk); while (!bench_idle);
    repeat (16) @(negedge clk);
    $display("covered %0d commands under %0d register settings: %0d pixels drawn,",
             n_cmds, n_settings, n_drawn);
    $display("  %0d reads, %0d whole-frame fade/blur passes", n_reads, n_fades);
    if (n_errors == 0) begin
      $display("[framebuffer_fade_blur_plot_unit] OK");
    end else begin
      $display("[framebuffer_fade_blur_plot_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/fbp_pkg.sv
design/fbp_ram.sv
design/fbp_alu.sv
design/framebuffer_fade_blur_plot_unit.sv
design/fbp_checker.sv
bench/tb.sv
